@@ rtl/pee_pkg.sv @@
// Shared types and constants for the positional escape expander.
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

    // Argument limit and command queue depth defaults
    localparam int MAX_ARGS_DEF  = 16;
    localparam int CMD_DEPTH_DEF = 4;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int NUM_W  = 5;
    localparam int KIND_W = 2;
    localparam int ACC_W  = 10;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARG     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [ACC_W-1:0]  RADIX      = 10'd10;

    // Decoded work for one text byte, results in slot order:
    // percent literal, argument reference, byte literal, end of text
    typedef struct packed {
        logic                pct;
        logic                arg_v;
        logic [NUM_W-1:0]    arg_num;
        logic                lit;
        logic [BYTE_W-1:0]   lit_byte;
        logic                fin;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

`default_nettype wire

@@ rtl/pee_front.sv @@
// Front end: parses text bytes and builds at most one command per byte.
`timescale 1ns / 1ps
`default_nettype none

module pee_front #(
    parameter int MAX_ARGS = pee_pkg::MAX_ARGS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_take,
    input  wire logic [pee_pkg::BYTE_W-1:0]  text_byte,
    input  wire logic                        is_last,
    input  wire logic                        cfg_valid,
    input  wire logic [pee_pkg::NUM_W-1:0]   cfg_data,
    output logic                             cmd_push,
    output pee_pkg::cmd_t                    cmd
);
    import pee_pkg::*;

    localparam logic [1:0] PH_PLAIN   = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [NUM_W-1:0] LIM_MAX = NUM_W'(MAX_ARGS);

    logic [1:0]        phase_reg, phase_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  arg_count_reg;

    logic [NUM_W-1:0]  lim;
    logic              is_digit, is_pct;
    logic [3:0]        digit;
    logic [NUM_W-1:0]  acc_base, acc_out;
    logic [ACC_W-1:0]  acc_wide;
    cmd_t              c;

    // Byte class and current limit
    assign lim      = (arg_count_reg > LIM_MAX) ? LIM_MAX : arg_count_reg;
    assign is_pct   = (text_byte == CH_PERCENT);
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign digit    = 4'(text_byte - CH_ZERO);

    // Saturating decimal accumulate
    assign acc_base = (phase_reg == PH_DIGITS) ? num_reg : '0;
    assign acc_wide = ACC_W'(acc_base) * RADIX + ACC_W'(digit);
    always_comb
    begin
        if (acc_base > lim)
            acc_out = acc_base;
        else if (acc_wide > ACC_W'(lim))
            acc_out = lim + NUM_W'(1);
        else
            acc_out = acc_wide[NUM_W-1:0];
    end

    // Parse step
    always_comb
    begin
        c          = '0;
        c.lit_byte = text_byte;
        phase_next = phase_reg;
        num_next   = num_reg;
        unique case (phase_reg)
            PH_PERCENT:
            begin
                if (is_pct)
                begin
                    c.pct      = 1'b1;
                    phase_next = PH_PLAIN;
                end
                else if (is_digit)
                begin
                    num_next   = acc_out;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    c.pct      = 1'b1;
                    c.lit      = 1'b1;
                    phase_next = PH_PLAIN;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                    num_next = acc_out;
                else
                begin
                    c.arg_v    = (num_reg != '0) && (num_reg <= lim);
                    c.arg_num  = num_reg;
                    c.lit      = !is_pct;
                    num_next   = '0;
                    phase_next = PH_PLAIN;
                end
            end
            default:
            begin
                if (is_pct)
                begin
                    if (is_last)
                        c.pct = 1'b1;
                    else
                        phase_next = PH_PERCENT;
                end
                else
                    c.lit = 1'b1;
                num_next = '0;
            end
        endcase

        // End of text closes an open reference
        if (is_last)
        begin
            if (phase_next == PH_DIGITS)
            begin
                c.arg_v   = (num_next != '0) && (num_next <= lim);
                c.arg_num = num_next;
            end
            c.fin      = 1'b1;
            phase_next = PH_PLAIN;
            num_next   = '0;
        end
    end

    assign cmd      = c;
    assign cmd_push = in_take && (c.pct || c.arg_v || c.lit || c.fin);

    // Parser state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            num_reg       <= '0;
            arg_count_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
                num_reg   <= num_next;
            end
            if (cfg_valid)
                arg_count_reg <= cfg_data;
        end
    end

    // Digit value is only held while inside a reference
    a_num_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DIGITS) |-> (num_reg == '0))
        else $error("digit value nonzero outside digits phase");

endmodule

`default_nettype wire

@@ rtl/pee_cmd_fifo.sv @@
// Short register queue carrying commands from front end to back end.
`timescale 1ns / 1ps
`default_nettype none

module pee_cmd_fifo #(
    parameter int WIDTH = pee_pkg::CMD_W,
    parameter int DEPTH = pee_pkg::CMD_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    output logic [WIDTH-1:0]       rd_data,
    output logic                   full,
    output logic                   empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("command queue count overflow");

endmodule

`default_nettype wire

@@ rtl/pee_back.sv @@
// Back end: expands each command into results through an output register.
`timescale 1ns / 1ps
`default_nettype none

module pee_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pee_pkg::cmd_t               cmd,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic                        out_take,
    output logic                             out_valid,
    output logic [pee_pkg::KIND_W-1:0]       kind,
    output logic [pee_pkg::BYTE_W-1:0]       out_byte,
    output logic [pee_pkg::NUM_W-1:0]        arg_number,
    output logic                             run_last
);
    import pee_pkg::*;

    // Slot mask bits
    localparam int S_PCT = 0;
    localparam int S_ARG = 1;
    localparam int S_LIT = 2;
    localparam int S_FIN = 3;

    logic [3:0]         mask_reg, mask_next;
    logic [BYTE_W-1:0]  cur_byte_reg;
    logic [NUM_W-1:0]   cur_num_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [NUM_W-1:0]   arg_reg;
    logic               last_reg;

    logic               out_free, emit;
    logic [3:0]         sel, mask_rest, mask_left;
    logic [KIND_W-1:0]  kind_new;
    logic [BYTE_W-1:0]  byte_new;
    logic [NUM_W-1:0]   arg_new;

    // Pick lowest pending slot
    assign sel       = mask_reg & (~mask_reg + 4'd1);
    assign mask_rest = mask_reg & ~sel;
    assign out_free  = !out_valid_reg || out_take;
    assign emit      = out_free && (mask_reg != '0);
    assign mask_left = emit ? mask_rest : mask_reg;
    assign cmd_pop   = !cmd_empty && (mask_left == '0);
    assign mask_next = cmd_pop ? {cmd.fin, cmd.lit, cmd.arg_v, cmd.pct} : mask_left;

    // Result fields of the selected slot
    always_comb
    begin
        kind_new = KIND_END;
        byte_new = '0;
        arg_new  = '0;
        if (sel[S_PCT])
        begin
            kind_new = KIND_LITERAL;
            byte_new = CH_PERCENT;
        end
        else if (sel[S_ARG])
        begin
            kind_new = KIND_ARG;
            arg_new  = cur_num_reg;
        end
        else if (sel[S_LIT])
        begin
            kind_new = KIND_LITERAL;
            byte_new = cur_byte_reg;
        end
    end

    // Current command payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_byte_reg <= cmd.lit_byte;
            cur_num_reg  <= cmd.arg_num;
        end
        if (emit)
        begin
            kind_reg <= kind_new;
            byte_reg <= byte_new;
            arg_reg  <= arg_new;
            last_reg <= (mask_rest == '0);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_byte   = byte_reg;
    assign arg_number = arg_reg;
    assign run_last   = last_reg;

    // No bubble while work is queued and the slot mask is drained
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_empty && mask_reg == '0) |-> cmd_pop)
        else $error("back end idle with queued command");

    // End of text is always the last result of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |-> last_reg)
        else $error("end result without run_last");

    // The end slot is never followed by another slot of the same command
    a_fin_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && sel[S_FIN]) |-> (mask_rest == '0))
        else $error("slot pending after end of text");

endmodule

`default_nettype wire

@@ rtl/positional_escape_expander.sv @@
// Top level of the positional escape expander.
// Path: the first result of a byte passes from the command queue through the slot mask
// into the back end's output register, which drives the result ports.
// Throughput: one byte per cycle when each byte yields at most one result and pop keeps up;
// the back end emits one result per cycle while results are taken, a byte's results in turn.
// A 4-entry command queue lets the parser run ahead of result backpressure.
// Reset (rst_n, async low) clears parser state, arg_count, queue and output.
`timescale 1ns / 1ps
`default_nettype none

module positional_escape_expander #(
    parameter int MAX_ARGS  = pee_pkg::MAX_ARGS_DEF,
    parameter int CMD_DEPTH = pee_pkg::CMD_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [pee_pkg::BYTE_W-1:0]  text_byte,
    input  wire logic                        is_last,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [pee_pkg::KIND_W-1:0]       kind,
    output logic [pee_pkg::BYTE_W-1:0]       out_byte,
    output logic [pee_pkg::NUM_W-1:0]        arg_number,
    output logic                             run_last,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pee_pkg::NUM_W-1:0]   cfg_data
);
    import pee_pkg::*;

    logic              in_take;
    logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
    cmd_t              cmd_in, cmd_out;
    logic [CMD_W-1:0]  cmd_rd_data;
    logic              out_valid, out_take;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign in_take   = push && !cmd_full;
    assign empty     = !out_valid;
    assign out_take  = pop && out_valid;

    // Parser
    pee_front #(
        .MAX_ARGS (MAX_ARGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .text_byte (text_byte),
        .is_last   (is_last),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    // Command queue
    pee_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_rd_data);

    // Result expander
    pee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_out),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .out_take   (out_take),
        .out_valid  (out_valid),
        .kind       (kind),
        .out_byte   (out_byte),
        .arg_number (arg_number),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

@@ tb/sv/positional_escape_expander_test.sv @@
// Self-checking testbench for the positional escape expander.
`timescale 1ns / 1ps

module positional_escape_expander_test;

    import pee_pkg::*;

    localparam int PHASE_BYTES = 67;    // text bytes per arg_count setting
    localparam int QUIET_FROM  = 370;   // no idling once this many bytes went in
    localparam int HOLD_AT     = 120;   // long receiver hold-off starts here
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 10;    // pipeline plus command queue, with margin

    // Tracks parser state and holds the results each accepted byte must produce
    class expansion_scoreboard;
        typedef enum logic [1:0] {SCAN_PLAIN, SCAN_PERCENT, SCAN_DIGITS} scan_t;
        typedef struct packed {
            logic [KIND_W-1:0] code;
            logic [BYTE_W-1:0] lit;
            logic [NUM_W-1:0]  num;
            logic              fin;
        } token_t;

        token_t      due[$];
        scan_t       scan;
        int unsigned value;
        logic [NUM_W-1:0] arg_count;
        int errors, accepted, checked, refs, ends, settings;

        function new();
            scan      = SCAN_PLAIN;
            value     = 0;
            arg_count = '0;
            settings  = 1;
        endfunction

        function void set_arg_count(logic [NUM_W-1:0] v);
            arg_count = v;
            settings++;
        endfunction

        function int unsigned limit();
            return (arg_count > MAX_ARGS_DEF) ? MAX_ARGS_DEF : arg_count;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void add(logic [KIND_W-1:0] code, logic [BYTE_W-1:0] lit,
                          logic [NUM_W-1:0] num);
            token_t t;
            t.code = code;
            t.lit  = lit;
            t.num  = num;
            t.fin  = 1'b0;
            due.push_back(t);
        endfunction

        // Decimal accumulation, saturating one above the limit
        function void extend(int unsigned d, int unsigned lim);
            int unsigned v;
            if (value <= lim) begin
                v = value * 10 + d;
                value = (v > lim) ? lim + 1 : v;
            end
        endfunction

        function void add_ref(int unsigned lim);
            if (value >= 1 && value <= lim)
                add(KIND_ARG, '0, NUM_W'(value));
        endfunction

        // Expected results of one accepted text byte
        function void note_byte(logic [BYTE_W-1:0] b, logic fin_in);
            int unsigned lim;
            bit digit;
            int first;
            token_t t;
            lim   = limit();
            digit = (b >= CH_ZERO) && (b <= CH_NINE);
            first = due.size();
            accepted++;
            case (scan)
                SCAN_PERCENT:
                begin
                    if (b == CH_PERCENT) begin
                        add(KIND_LITERAL, CH_PERCENT, '0);
                        scan = SCAN_PLAIN;
                    end else if (digit) begin
                        value = 0;
                        extend(b - CH_ZERO, lim);
                        scan = SCAN_DIGITS;
                    end else begin
                        // lone percent stands for itself
                        add(KIND_LITERAL, CH_PERCENT, '0);
                        add(KIND_LITERAL, b, '0);
                        scan = SCAN_PLAIN;
                    end
                end
                SCAN_DIGITS:
                begin
                    if (digit) begin
                        extend(b - CH_ZERO, lim);
                    end else begin
                        add_ref(lim);
                        if (b != CH_PERCENT)
                            add(KIND_LITERAL, b, '0);
                        value = 0;
                        scan  = SCAN_PLAIN;
                    end
                end
                default:
                begin
                    if (b == CH_PERCENT) begin
                        if (fin_in)
                            add(KIND_LITERAL, CH_PERCENT, '0);
                        else
                            scan = SCAN_PERCENT;
                    end else begin
                        add(KIND_LITERAL, b, '0);
                    end
                    value = 0;
                end
            endcase
            // end of text: flush a pending reference, then the end marker
            if (fin_in) begin
                if (scan == SCAN_DIGITS)
                    add_ref(lim);
                add(KIND_END, '0, '0);
                scan  = SCAN_PLAIN;
                value = 0;
            end
            if (due.size() > first) begin
                t = due.pop_back();
                t.fin = 1'b1;
                due.push_back(t);
            end
        endfunction

        function void compare(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // Check one result transfer against the oldest expectation
        function void check_result(logic [KIND_W-1:0] code, logic [BYTE_W-1:0] lit,
                                   logic [NUM_W-1:0] num, logic fin);
            token_t t;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind %0d byte %0d arg %0d last %0b",
                         $time, code, lit, num, fin);
                return;
            end
            t = due.pop_front();
            checked++;
            if (t.code == KIND_ARG)
                refs++;
            if (t.code == KIND_END)
                ends++;
            compare("kind", t.code, code);
            compare("out_byte", t.lit, lit);
            compare("arg_number", t.num, num);
            compare("run_last", t.fin, fin);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [BYTE_W-1:0]  text_byte = '0;
    logic               is_last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [NUM_W-1:0]   arg_number;
    logic               run_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [NUM_W-1:0]   cfg_data = '0;

    expansion_scoreboard sb = new();

    positional_escape_expander DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .is_last    (is_last),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .out_byte   (out_byte),
        .arg_number (arg_number),
        .run_last   (run_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("positional_escape_expander_test NOT OK");
        $finish;
    end

    // Result transfers are checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(kind, out_byte, arg_number, run_last);
    end

    // Receiver: random pop bursts, one long hold-off to fill the block
    initial
    begin : pop_driver
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && sb.accepted >= HOLD_AT) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (sb.accepted < QUIET_FROM && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // One text byte transfer; entered and left at a falling edge, push left high
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        if (sb.accepted < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        is_last   <= fin;
        do @(posedge clk); while (full);
        sb.note_byte(b, fin);
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // A whole template of random pieces, mostly well-formed escapes
    task automatic send_random_text();
        logic [BYTE_W-1:0] chars[$];
        logic [BYTE_W-1:0] b;
        int unsigned v;
        int unsigned lim;
        lim = sb.limit();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    chars.push_back(CH_PERCENT);
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            // long digit run, saturates
                            repeat ($urandom_range(3, 5))
                                chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        end
                        default:
                        begin
                            if ($urandom_range(0, 5) == 0)
                                chars.push_back(CH_ZERO);
                            v = $urandom_range(0, lim + 2);
                            if (v >= 10)
                                chars.push_back(CH_ZERO + 8'(v / 10));
                            chars.push_back(CH_ZERO + 8'(v % 10));
                        end
                    endcase
                    if ($urandom_range(0, 2) != 0)
                        chars.push_back(CH_PERCENT);
                end
                4:
                begin
                    chars.push_back(CH_PERCENT);
                    chars.push_back(CH_PERCENT);
                end
                5:
                begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_PERCENT || (b >= CH_ZERO && b <= CH_NINE));
                    chars.push_back(CH_PERCENT);
                    chars.push_back(b);
                end
                6, 7, 8:
                    chars.push_back(8'($urandom_range(0, 255)));
                default:
                    chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            endcase
        end
        foreach (chars[i])
            send_byte(chars[i], i == chars.size() - 1);
    endtask

    // Stop sending and let every expected result and the pipeline drain
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_arg_count(input logic [NUM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_arg_count(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin : stimulus
        logic [NUM_W-1:0] plan[6];
        int target;
        plan = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd0};
        plan[5] = NUM_W'($urandom_range(0, 31));
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset value: no argument available, trailing digits yield nothing
        send_string("%1");
        wait_idle();

        // directed: byte extremes, every escape form, saturation, leading zero
        write_arg_count(5'd16);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_string("%%%q%3%%16a%0%%05%%17%");
        send_string("%");

        // random templates under several argument counts
        foreach (plan[p]) begin
            wait_idle();
            write_arg_count(plan[p]);
            target = 28 + (p + 1) * PHASE_BYTES;
            while (sb.accepted < target)
                send_random_text();
        end

        wait_idle();
        $display("Sent %0d text bytes under %0d arg_count settings; checked %0d results",
                 sb.accepted, sb.settings, sb.checked);
        $display("including %0d argument references and %0d end markers", sb.refs, sb.ends);
        if (sb.errors == 0)
            $display("positional_escape_expander_test OK");
        else
            $display("positional_escape_expander_test NOT OK");
        $finish;
    end

endmodule

@@ positional_escape_expander.f @@
rtl/pee_pkg.sv
rtl/pee_front.sv
rtl/pee_cmd_fifo.sv
rtl/pee_back.sv
rtl/positional_escape_expander.sv
tb/sv/positional_escape_expander_test.sv
